// File: design/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define SGPF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Checked at every edge, reset included.
`define SGPF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error(msg);

`endif

// File: design/sgpf_pkg.sv
`default_nettype none

package sgpf_pkg;

    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 64;
    localparam int MAX_SCALE     = 4;

    localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
    localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int SCALE_W     = $clog2(MAX_SCALE + 1);
    localparam int GLYPH_SIZE  = 8;
    localparam int GLYPH_COUNT = 64;
    // Pixel coordinates reach the far corner of a fully magnified glyph.
    localparam int PX_W = $clog2(256 + GLYPH_SIZE * MAX_SCALE);
    localparam int PY_W = $clog2(128 + GLYPH_SIZE * MAX_SCALE);

    // Stream packing.
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 16;
    localparam int X_LSB     = 0;
    localparam int Y_LSB     = 8;
    localparam int CHAR_LSB  = 15;
    localparam int SCALE_LSB = 23;
    localparam int INDEX_LSB = 26;
    localparam int RES_CHANGED_BIT = 8;

    // Character mapping.
    localparam logic [7:0] CHAR_FIRST    = 8'h20;
    localparam logic [7:0] CHAR_LAST     = 8'h5F;
    localparam logic [7:0] CHAR_FALLBACK = 8'h3F;
    localparam logic [7:0] LOWER_FIRST   = 8'h61;
    localparam logic [7:0] LOWER_LAST    = 8'h7A;
    localparam logic [7:0] CASE_OFFSET   = 8'h20;

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_DRAW   = 2'd1,
        MODE_READ   = 2'd2,
        MODE_COMMIT = 2'd3
    } op_mode_t;

    // Row 0 first; bit 0 of a row is the leftmost pixel.
    typedef logic [0:GLYPH_SIZE-1][7:0] glyph_t;

    typedef struct packed {
        logic load;
        logic advance;
    } walk_ctrl_t;

    typedef struct packed {
        logic              empty;
        logic              hit;
        logic              last;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        mask;
    } walk_stat_t;

    localparam glyph_t GLYPH_ROM [0:GLYPH_COUNT-1] = '{
        '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'h18,8'h3C,8'h3C,8'h18,8'h18,8'h00,8'h18,8'h00},
        '{8'h36,8'h36,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'h36,8'h36,8'h7F,8'h36,8'h7F,8'h36,8'h36,8'h00},
        '{8'h0C,8'h3E,8'h03,8'h1E,8'h30,8'h1F,8'h0C,8'h00},
        '{8'h00,8'h63,8'h33,8'h18,8'h0C,8'h66,8'h63,8'h00},
        '{8'h1C,8'h36,8'h1C,8'h6E,8'h3B,8'h33,8'h6E,8'h00},
        '{8'h06,8'h06,8'h03,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'h18,8'h0C,8'h06,8'h06,8'h06,8'h0C,8'h18,8'h00},
        '{8'h06,8'h0C,8'h18,8'h18,8'h18,8'h0C,8'h06,8'h00},
        '{8'h00,8'h66,8'h3C,8'hFF,8'h3C,8'h66,8'h00,8'h00},
        '{8'h00,8'h0C,8'h0C,8'h3F,8'h0C,8'h0C,8'h00,8'h00},
        '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h0C,8'h0C,8'h06},
        '{8'h00,8'h00,8'h00,8'h3F,8'h00,8'h00,8'h00,8'h00},
        '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h0C,8'h0C,8'h00},
        '{8'h60,8'h30,8'h18,8'h0C,8'h06,8'h03,8'h01,8'h00},
        '{8'h3E,8'h63,8'h73,8'h7B,8'h6F,8'h67,8'h3E,8'h00},
        '{8'h0C,8'h0E,8'h0C,8'h0C,8'h0C,8'h0C,8'h3F,8'h00},
        '{8'h1E,8'h33,8'h30,8'h1C,8'h06,8'h33,8'h3F,8'h00},
        '{8'h1E,8'h33,8'h30,8'h1C,8'h30,8'h33,8'h1E,8'h00},
        '{8'h38,8'h3C,8'h36,8'h33,8'h7F,8'h30,8'h78,8'h00},
        '{8'h3F,8'h03,8'h1F,8'h30,8'h30,8'h33,8'h1E,8'h00},
        '{8'h1C,8'h06,8'h03,8'h1F,8'h33,8'h33,8'h1E,8'h00},
        '{8'h3F,8'h33,8'h30,8'h18,8'h0C,8'h0C,8'h0C,8'h00},
        '{8'h1E,8'h33,8'h33,8'h1E,8'h33,8'h33,8'h1E,8'h00},
        '{8'h1E,8'h33,8'h33,8'h3E,8'h30,8'h18,8'h0E,8'h00},
        '{8'h00,8'h0C,8'h0C,8'h00,8'h00,8'h0C,8'h0C,8'h00},
        '{8'h00,8'h0C,8'h0C,8'h00,8'h00,8'h0C,8'h0C,8'h06},
        '{8'h18,8'h0C,8'h06,8'h03,8'h06,8'h0C,8'h18,8'h00},
        '{8'h00,8'h00,8'h3F,8'h00,8'h00,8'h3F,8'h00,8'h00},
        '{8'h06,8'h0C,8'h18,8'h30,8'h18,8'h0C,8'h06,8'h00},
        '{8'h1E,8'h33,8'h30,8'h18,8'h0C,8'h00,8'h0C,8'h00},
        '{8'h3E,8'h63,8'h7B,8'h7B,8'h7B,8'h03,8'h1E,8'h00},
        '{8'h0C,8'h1E,8'h33,8'h33,8'h3F,8'h33,8'h33,8'h00},
        '{8'h3F,8'h66,8'h66,8'h3E,8'h66,8'h66,8'h3F,8'h00},
        '{8'h3C,8'h66,8'h03,8'h03,8'h03,8'h66,8'h3C,8'h00},
        '{8'h1F,8'h36,8'h66,8'h66,8'h66,8'h36,8'h1F,8'h00},
        '{8'h7F,8'h46,8'h16,8'h1E,8'h16,8'h46,8'h7F,8'h00},
        '{8'h7F,8'h46,8'h16,8'h1E,8'h16,8'h06,8'h0F,8'h00},
        '{8'h3C,8'h66,8'h03,8'h03,8'h73,8'h66,8'h7C,8'h00},
        '{8'h33,8'h33,8'h33,8'h3F,8'h33,8'h33,8'h33,8'h00},
        '{8'h1E,8'h0C,8'h0C,8'h0C,8'h0C,8'h0C,8'h1E,8'h00},
        '{8'h78,8'h30,8'h30,8'h30,8'h33,8'h33,8'h1E,8'h00},
        '{8'h67,8'h66,8'h36,8'h1E,8'h36,8'h66,8'h67,8'h00},
        '{8'h0F,8'h06,8'h06,8'h06,8'h46,8'h66,8'h7F,8'h00},
        '{8'h63,8'h77,8'h7F,8'h7F,8'h6B,8'h63,8'h63,8'h00},
        '{8'h63,8'h67,8'h6F,8'h7B,8'h73,8'h63,8'h63,8'h00},
        '{8'h1C,8'h36,8'h63,8'h63,8'h63,8'h36,8'h1C,8'h00},
        '{8'h3F,8'h66,8'h66,8'h3E,8'h06,8'h06,8'h0F,8'h00},
        '{8'h1E,8'h33,8'h33,8'h33,8'h3B,8'h1E,8'h38,8'h00},
        '{8'h3F,8'h66,8'h66,8'h3E,8'h36,8'h66,8'h67,8'h00},
        '{8'h1E,8'h33,8'h07,8'h0E,8'h38,8'h33,8'h1E,8'h00},
        '{8'h3F,8'h2D,8'h0C,8'h0C,8'h0C,8'h0C,8'h1E,8'h00},
        '{8'h33,8'h33,8'h33,8'h33,8'h33,8'h33,8'h3F,8'h00},
        '{8'h33,8'h33,8'h33,8'h33,8'h33,8'h1E,8'h0C,8'h00},
        '{8'h63,8'h63,8'h63,8'h6B,8'h7F,8'h77,8'h63,8'h00},
        '{8'h63,8'h63,8'h36,8'h1C,8'h1C,8'h36,8'h63,8'h00},
        '{8'h33,8'h33,8'h33,8'h1E,8'h0C,8'h0C,8'h1E,8'h00},
        '{8'h7F,8'h63,8'h31,8'h18,8'h4C,8'h66,8'h7F,8'h00},
        '{8'h1E,8'h06,8'h06,8'h06,8'h06,8'h06,8'h1E,8'h00},
        '{8'h03,8'h06,8'h0C,8'h18,8'h30,8'h60,8'h40,8'h00},
        '{8'h1E,8'h18,8'h18,8'h18,8'h18,8'h18,8'h1E,8'h00},
        '{8'h08,8'h1C,8'h36,8'h63,8'h00,8'h00,8'h00,8'h00},
        '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'hFF}
    };

    // Lowercase folds to uppercase; anything outside the font draws as '?'.
    function automatic logic [5:0] rom_slot(input logic [7:0] code);
        logic [7:0] c;
        c = code;
        if (c inside {[LOWER_FIRST:LOWER_LAST]}) begin
            c = c - CASE_OFFSET;
        end
        if (!(c inside {[CHAR_FIRST:CHAR_LAST]})) begin
            c = CHAR_FALLBACK;
        end
        return 6'(c - CHAR_FIRST);
    endfunction

endpackage

`default_nettype wire

// File: design/sgpf_ram.sv
`default_nettype none

module sgpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: design/sgpf_glyph_walker.sv
`default_nettype none

// Steps through every magnified pixel of one glyph: sub-column fastest, then
// glyph column, sub-row, glyph row. Reports the frame byte and bit of the
// current pixel and whether it is lit and on screen.
module sgpf_glyph_walker (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire sgpf_pkg::walk_ctrl_t ctrl,
    input  wire logic [7:0]           x_pos,
    input  wire logic [6:0]           y_pos,
    input  wire logic [7:0]           char_code,
    input  wire logic [2:0]           glyph_scale,
    output sgpf_pkg::walk_stat_t      stat
);

    localparam int SW = sgpf_pkg::SCALE_W;
    localparam int XW = sgpf_pkg::PX_W;
    localparam int YW = sgpf_pkg::PY_W;

    logic [7:0]       x0_reg;
    logic [6:0]       y0_reg;
    sgpf_pkg::glyph_t glyph_reg;
    logic [SW-1:0]    scale_reg, scale_next;
    logic [SW-1:0]    sx_reg, sx_next, sy_reg, sy_next;
    logic [2:0]       gx_reg, gx_next, gy_reg, gy_next;

    logic [SW-1:0] scale_m1;
    logic          sx_end, gx_end, sy_end, gy_end;
    logic [XW-1:0] px;
    logic [YW-1:0] py;
    logic          on_screen;

    always_comb begin
        scale_m1 = scale_reg - SW'(1);
        sx_end   = (sx_reg == scale_m1);
        sy_end   = (sy_reg == scale_m1);
        gx_end   = (gx_reg == 3'(sgpf_pkg::GLYPH_SIZE - 1));
        gy_end   = (gy_reg == 3'(sgpf_pkg::GLYPH_SIZE - 1));

        px = XW'(x0_reg) + XW'(gx_reg) * XW'(scale_reg) + XW'(sx_reg);
        py = YW'(y0_reg) + YW'(gy_reg) * YW'(scale_reg) + YW'(sy_reg);
        on_screen = (px < XW'(sgpf_pkg::SCREEN_WIDTH)) &&
                    (py < YW'(sgpf_pkg::SCREEN_HEIGHT));

        stat.empty = (scale_reg == '0);
        stat.hit   = on_screen && glyph_reg[gy_reg][gx_reg];
        stat.last  = sx_end && gx_end && sy_end && gy_end;
        stat.addr  = sgpf_pkg::ADDR_W'(32'(py >> 3) * sgpf_pkg::SCREEN_WIDTH + 32'(px));
        stat.mask  = 8'(1) << py[2:0];
    end

    always_comb begin
        scale_next = scale_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        gx_next    = gx_reg;
        gy_next    = gy_reg;
        if (ctrl.load) begin
            if (32'(glyph_scale) > sgpf_pkg::MAX_SCALE) begin
                scale_next = SW'(sgpf_pkg::MAX_SCALE);
            end else begin
                scale_next = SW'(glyph_scale);
            end
            sx_next = '0;
            sy_next = '0;
            gx_next = '0;
            gy_next = '0;
        end else if (ctrl.advance) begin
            sx_next = sx_end ? '0 : sx_reg + SW'(1);
            if (sx_end) begin
                gx_next = gx_reg + 3'd1;
                if (gx_end) begin
                    sy_next = sy_end ? '0 : sy_reg + SW'(1);
                    if (sy_end) begin
                        gy_next = gy_reg + 3'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= '0;
            sx_reg    <= '0;
            sy_reg    <= '0;
            gx_reg    <= '0;
            gy_reg    <= '0;
        end else begin
            scale_reg <= scale_next;
            sx_reg    <= sx_next;
            sy_reg    <= sy_next;
            gx_reg    <= gx_next;
            gy_reg    <= gy_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            x0_reg    <= x_pos;
            y0_reg    <= y_pos;
            glyph_reg <= sgpf_pkg::GLYPH_ROM[sgpf_pkg::rom_slot(char_code)];
        end
    end

endmodule

`default_nettype wire

// File: design/scaled_glyph_page_framebuffer.sv
`default_nettype none

// Paged monochrome text framebuffer (128x64 pixels, eight pages of 128 bytes)
// with one result transaction per input transaction. Every operation runs
// through the frame memory under a small sequencer, and the input
// side is not ready until the current operation is finished. After reset the
// block zeroes the frame memory before it accepts anything. A clear writes
// one byte per cycle; a commit compares and copies one byte per cycle against
// the shadow memory; a character draw visits each of the 64*scale*scale
// magnified pixel positions and does a read-modify-write of the byte for
// each lit pixel that lands on screen. Scales above 4 are drawn at 4, and
// a scale of 0 draws nothing.
module scaled_glyph_page_framebuffer (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // x_pos[7:0], y_pos[14:8], char_code[22:15], glyph_scale[25:23],
    // byte_index[35:26], zero fill above
    input  wire logic [sgpf_pkg::S_TDATA_W-1:0] s_tdata,
    // mode[1:0]
    input  wire logic [1:0]                     s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // byte_value[7:0], frame_changed[8], zero fill above
    output logic [sgpf_pkg::M_TDATA_W-1:0]      m_tdata
);

    localparam int AW = sgpf_pkg::ADDR_W;

    typedef enum logic [8:0] {
        ST_INIT    = 9'b000000001,
        ST_IDLE    = 9'b000000010,
        ST_CLEAR   = 9'b000000100,
        ST_DRAW    = 9'b000001000,
        ST_DRAW_WR = 9'b000010000,
        ST_RD_ADDR = 9'b000100000,
        ST_RD_DATA = 9'b001000000,
        ST_CMP     = 9'b010000000,
        ST_DONE    = 9'b100000000
    } state_t;

    state_t            state_reg, state_next;
    logic [AW-1:0]     cnt_reg, cnt_next;
    logic              issue_done_reg, issue_done_next;
    logic              cmp_valid_reg, cmp_valid_next;
    logic [AW-1:0]     cmp_addr_reg;
    logic              diff_reg, diff_next;
    logic              shadow_valid_reg, shadow_valid_next;
    logic [9:0]        index_reg, index_next;
    logic [7:0]        res_byte_reg, res_byte_next;
    logic              res_changed_reg, res_changed_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [7:0]        m_byte_reg, m_byte_next;
    logic              m_changed_reg, m_changed_next;

    sgpf_pkg::walk_ctrl_t walk_ctrl;
    sgpf_pkg::walk_stat_t walk_stat;
    sgpf_pkg::op_mode_t   in_mode;

    logic          fr_wr_en;
    logic [AW-1:0] fr_wr_addr, fr_rd_addr;
    logic [7:0]    fr_wr_data, fr_rd_data;
    logic          sh_wr_en;
    logic [7:0]    sh_rd_data;

    logic cnt_last, out_free, index_in_range;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(sgpf_pkg::M_TDATA_W - 9)'(0), m_changed_reg, m_byte_reg};
    assign in_mode  = sgpf_pkg::op_mode_t'(s_tuser);

    sgpf_glyph_walker u_walker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (walk_ctrl),
        .x_pos       (s_tdata[sgpf_pkg::X_LSB +: 8]),
        .y_pos       (s_tdata[sgpf_pkg::Y_LSB +: 7]),
        .char_code   (s_tdata[sgpf_pkg::CHAR_LSB +: 8]),
        .glyph_scale (s_tdata[sgpf_pkg::SCALE_LSB +: 3]),
        .stat        (walk_stat)
    );

    sgpf_ram #(.WIDTH(8), .DEPTH(sgpf_pkg::STORE_BYTES)) u_frame_ram (
        .aclk    (aclk),
        .wr_en   (fr_wr_en),
        .wr_addr (fr_wr_addr),
        .wr_data (fr_wr_data),
        .rd_addr (fr_rd_addr),
        .rd_data (fr_rd_data)
    );

    // The shadow is written in the cycle after the read of the same address,
    // so a commit compares and copies in a single sweep.
    sgpf_ram #(.WIDTH(8), .DEPTH(sgpf_pkg::STORE_BYTES)) u_shadow_ram (
        .aclk    (aclk),
        .wr_en   (sh_wr_en),
        .wr_addr (cmp_addr_reg),
        .wr_data (fr_rd_data),
        .rd_addr (cnt_reg),
        .rd_data (sh_rd_data)
    );

    always_comb begin
        cnt_last       = (cnt_reg == AW'(sgpf_pkg::STORE_BYTES - 1));
        out_free       = !m_tvalid_reg || m_tready;
        index_in_range = (32'(index_reg) < sgpf_pkg::STORE_BYTES);

        state_next        = state_reg;
        cnt_next          = cnt_reg;
        issue_done_next   = issue_done_reg;
        cmp_valid_next    = 1'b0;
        diff_next         = diff_reg;
        shadow_valid_next = shadow_valid_reg;
        index_next        = index_reg;
        res_byte_next     = res_byte_reg;
        res_changed_next  = res_changed_reg;
        m_tvalid_next     = m_tvalid_reg && !m_tready;
        m_byte_next       = m_byte_reg;
        m_changed_next    = m_changed_reg;

        walk_ctrl  = '0;
        fr_wr_en   = 1'b0;
        fr_wr_addr = walk_stat.addr;
        fr_wr_data = fr_rd_data | walk_stat.mask;
        fr_rd_addr = walk_stat.addr;
        sh_wr_en   = 1'b0;

        case (state_reg)
            ST_INIT, ST_CLEAR: begin
                fr_wr_en   = 1'b1;
                fr_wr_addr = cnt_reg;
                fr_wr_data = '0;
                cnt_next   = cnt_last ? '0 : cnt_reg + AW'(1);
                if (cnt_last) begin
                    state_next = (state_reg == ST_INIT) ? ST_IDLE : ST_DONE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    walk_ctrl.load   = 1'b1;
                    index_next       = s_tdata[sgpf_pkg::INDEX_LSB +: 10];
                    res_byte_next    = '0;
                    res_changed_next = 1'b0;
                    cnt_next         = '0;
                    issue_done_next  = 1'b0;
                    diff_next        = 1'b0;
                    case (in_mode)
                        sgpf_pkg::MODE_CLEAR:  state_next = ST_CLEAR;
                        sgpf_pkg::MODE_DRAW:   state_next = ST_DRAW;
                        sgpf_pkg::MODE_READ:   state_next = ST_RD_ADDR;
                        sgpf_pkg::MODE_COMMIT: state_next = ST_CMP;
                        default:               state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DRAW: begin
                // The read of the pixel's byte is issued here; the merge
                // and write follow in the next cycle.
                if (walk_stat.empty) begin
                    state_next = ST_DONE;
                end else if (walk_stat.hit) begin
                    state_next = ST_DRAW_WR;
                end else if (walk_stat.last) begin
                    state_next = ST_DONE;
                end else begin
                    walk_ctrl.advance = 1'b1;
                end
            end
            ST_DRAW_WR: begin
                fr_wr_en = 1'b1;
                if (walk_stat.last) begin
                    state_next = ST_DONE;
                end else begin
                    walk_ctrl.advance = 1'b1;
                    state_next        = ST_DRAW;
                end
            end
            ST_RD_ADDR: begin
                fr_rd_addr = AW'(index_reg);
                state_next = ST_RD_DATA;
            end
            ST_RD_DATA: begin
                res_byte_next = index_in_range ? fr_rd_data : '0;
                state_next    = ST_DONE;
            end
            ST_CMP: begin
                fr_rd_addr     = cnt_reg;
                cmp_valid_next = !issue_done_reg;
                if (!issue_done_reg) begin
                    cnt_next        = cnt_last ? '0 : cnt_reg + AW'(1);
                    issue_done_next = cnt_last;
                end
                if (cmp_valid_reg) begin
                    sh_wr_en  = 1'b1;
                    diff_next = diff_reg || (fr_rd_data != sh_rd_data);
                end
                if (issue_done_reg && !cmp_valid_reg) begin
                    res_changed_next  = !shadow_valid_reg || diff_reg;
                    shadow_valid_next = 1'b1;
                    state_next        = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next  = 1'b1;
                    m_byte_next    = res_byte_reg;
                    m_changed_next = res_changed_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_INIT;
            cnt_reg          <= '0;
            issue_done_reg   <= 1'b0;
            cmp_valid_reg    <= 1'b0;
            diff_reg         <= 1'b0;
            shadow_valid_reg <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            issue_done_reg   <= issue_done_next;
            cmp_valid_reg    <= cmp_valid_next;
            diff_reg         <= diff_next;
            shadow_valid_reg <= shadow_valid_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmp_addr_reg    <= cnt_reg;
        index_reg       <= index_next;
        res_byte_reg    <= res_byte_next;
        res_changed_reg <= res_changed_next;
        m_byte_reg      <= m_byte_next;
        m_changed_reg   <= m_changed_next;
    end

endmodule

`default_nettype wire

// File: design/sgpf_checker.sv
`default_nettype none

`include "assert_macros.svh"

module sgpf_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [sgpf_pkg::M_TDATA_W-1:0] m_tdata
);

    // Reset leaves no result pending and starts the memory sweep.
    `SGPF_ASSERT_ALWAYS(a_reset_quiet, !aresetn |=> (!m_tvalid && !s_tready),
                        "busy after reset")

    // An accept always moves the sequencer out of the idle state, dropping ready.
    `SGPF_ASSERT(a_busy_after_accept, (s_tvalid && s_tready) |=> !s_tready,
                 "accepted twice in a row")

    `SGPF_ASSERT(a_result_hold,
                 (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)),
                 "result changed while stalled")

    // A result is either a read byte or a commit flag, never both.
    `SGPF_ASSERT(a_result_kind,
                 m_tvalid |-> (!m_tdata[sgpf_pkg::RES_CHANGED_BIT] || (m_tdata[7:0] == 8'h00)),
                 "read byte and change flag both set")

endmodule

bind scaled_glyph_page_framebuffer sgpf_checker u_sgpf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// File: verif/scaled_glyph_page_framebuffer_tb.sv
`timescale 1ns / 100ps

module scaled_glyph_page_framebuffer_tb;

    typedef sgpf_pkg::op_mode_t op_mode_t;

    localparam int SCREEN_WIDTH    = sgpf_pkg::SCREEN_WIDTH;
    localparam int SCREEN_HEIGHT   = sgpf_pkg::SCREEN_HEIGHT;
    localparam int MAX_SCALE       = sgpf_pkg::MAX_SCALE;
    localparam int STORE_BYTES     = sgpf_pkg::STORE_BYTES;
    localparam int S_TDATA_W       = sgpf_pkg::S_TDATA_W;
    localparam int M_TDATA_W       = sgpf_pkg::M_TDATA_W;
    localparam int RES_CHANGED_BIT = sgpf_pkg::RES_CHANGED_BIT;

    localparam int RANDOM_OPS  = 1200;
    localparam int QUIET_TAIL  = 150;
    localparam int CYCLE_LIMIT = 10_000_000;
    localparam int SETTLE      = 64;

    localparam logic [7:0] ASCII_SPACE    = 8'h20;
    localparam logic [7:0] ASCII_LAST     = 8'h5F;
    localparam logic [7:0] ASCII_QUESTION = 8'h3F;
    localparam logic [7:0] ASCII_LOWER_A  = 8'h61;
    localparam logic [7:0] ASCII_LOWER_Z  = 8'h7A;
    localparam logic [7:0] ASCII_DEL      = 8'h7F;

    // One entry per font slot, row 0 in the top byte; bit 0 of a row is the left pixel.
    localparam logic [0:63][63:0] FONT_ROWS = {
        64'h0000000000000000, 64'h183C3C1818001800, 64'h3636000000000000,
        64'h36367F367F363600, 64'h0C3E031E301F0C00, 64'h006333180C666300,
        64'h1C361C6E3B336E00, 64'h0606030000000000, 64'h180C0606060C1800,
        64'h060C1818180C0600, 64'h00663CFF3C660000, 64'h000C0C3F0C0C0000,
        64'h00000000000C0C06, 64'h0000003F00000000, 64'h00000000000C0C00,
        64'h6030180C06030100, 64'h3E63737B6F673E00, 64'h0C0E0C0C0C0C3F00,
        64'h1E33301C06333F00, 64'h1E33301C30331E00, 64'h383C36337F307800,
        64'h3F031F3030331E00, 64'h1C06031F33331E00, 64'h3F3330180C0C0C00,
        64'h1E33331E33331E00, 64'h1E33333E30180E00, 64'h000C0C00000C0C00,
        64'h000C0C00000C0C06, 64'h180C0603060C1800, 64'h00003F00003F0000,
        64'h060C1830180C0600, 64'h1E3330180C000C00, 64'h3E637B7B7B031E00,
        64'h0C1E33333F333300, 64'h3F66663E66663F00, 64'h3C66030303663C00,
        64'h1F36666666361F00, 64'h7F46161E16467F00, 64'h7F46161E16060F00,
        64'h3C66030373667C00, 64'h3333333F33333300, 64'h1E0C0C0C0C0C1E00,
        64'h7830303033331E00, 64'h6766361E36666700, 64'h0F06060646667F00,
        64'h63777F7F6B636300, 64'h63676F7B73636300, 64'h1C36636363361C00,
        64'h3F66663E06060F00, 64'h1E3333333B1E3800, 64'h3F66663E36666700,
        64'h1E33070E38331E00, 64'h3F2D0C0C0C0C1E00, 64'h3333333333333F00,
        64'h33333333331E0C00, 64'h6363636B7F776300, 64'h6363361C1C366300,
        64'h3333331E0C0C1E00, 64'h7F6331184C667F00, 64'h1E06060606061E00,
        64'h03060C1830604000, 64'h1E18181818181E00, 64'h081C366300000000,
        64'h00000000000000FF
    };

    typedef struct {
        op_mode_t   mode;
        logic [7:0] x;
        logic [6:0] y;
        logic [7:0] ch;
        logic [2:0] scale;
        logic [9:0] idx;
        bit         typed;        // expected result given in the table
        logic [7:0] typed_byte;
        logic       typed_changed;
    } text_op_t;

    typedef struct {
        logic [7:0] byte_value;
        logic       frame_changed;
    } frame_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [1:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    logic [7:0]    fb_model [0:STORE_BYTES-1];
    logic [7:0]    shadow_model [0:STORE_BYTES-1];
    bit            shadow_ok;
    frame_result_t pending_results [$];
    frame_result_t want;
    frame_result_t got;
    text_op_t      cur_op;
    text_op_t      dir_ops [$];
    int            fail_count = 0;
    int            sent_ops = 0;
    int            cycle_count = 0;
    int            rx_hold = 0;
    bit            tx_idle_on = 1'b0;
    bit            rx_idle_on = 1'b0;

    scaled_glyph_page_framebuffer u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 aclk = ~aclk;

    function automatic logic [5:0] glyph_slot(input logic [7:0] code);
        logic [7:0] c;
        c = code;
        if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z) begin
            c = c - (ASCII_LOWER_A - "A");
        end
        if (c < ASCII_SPACE || c > ASCII_LAST) begin
            c = ASCII_QUESTION;
        end
        return 6'(c - ASCII_SPACE);
    endfunction

    // Updates the framebuffer copy for one operation and returns its result.
    function automatic frame_result_t apply_op(input text_op_t t);
        frame_result_t r;
        int            s;
        int            px;
        int            py;
        logic [5:0]    slot;
        logic [7:0]    row;
        bit            differs;
        r.byte_value    = 8'h00;
        r.frame_changed = 1'b0;
        case (t.mode)
            sgpf_pkg::MODE_CLEAR: begin
                for (int i = 0; i < STORE_BYTES; i++) fb_model[i] = 8'h00;
            end
            sgpf_pkg::MODE_DRAW: begin
                s    = (t.scale > MAX_SCALE) ? MAX_SCALE : int'(t.scale);
                slot = glyph_slot(t.ch);
                for (int gy = 0; gy < 8; gy++) begin
                    row = FONT_ROWS[slot][63 - 8 * gy -: 8];
                    for (int gx = 0; gx < 8; gx++) begin
                        if (row[gx]) begin
                            for (int sy = 0; sy < s; sy++) begin
                                for (int sx = 0; sx < s; sx++) begin
                                    px = int'(t.x) + gx * s + sx;
                                    py = int'(t.y) + gy * s + sy;
                                    if (px < SCREEN_WIDTH && py < SCREEN_HEIGHT) begin
                                        fb_model[(py / 8) * SCREEN_WIDTH + px][py % 8] = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                end
            end
            sgpf_pkg::MODE_READ: begin
                if (t.idx < STORE_BYTES) r.byte_value = fb_model[t.idx];
            end
            sgpf_pkg::MODE_COMMIT: begin
                differs = !shadow_ok;
                for (int i = 0; i < STORE_BYTES; i++) begin
                    if (shadow_model[i] != fb_model[i]) differs = 1'b1;
                end
                if (differs) begin
                    for (int i = 0; i < STORE_BYTES; i++) shadow_model[i] = fb_model[i];
                    shadow_ok       = 1'b1;
                    r.frame_changed = 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic text_op_t op_row(input op_mode_t mode, input int x, input int y,
                                        input int ch, input int scale, input int idx,
                                        input bit typed, input int tb, input bit tc);
        text_op_t t;
        t.mode          = mode;
        t.x             = 8'(x);
        t.y             = 7'(y);
        t.ch            = 8'(ch);
        t.scale         = 3'(scale);
        t.idx           = 10'(idx);
        t.typed         = typed;
        t.typed_byte    = 8'(tb);
        t.typed_changed = tc;
        return t;
    endfunction

    function automatic text_op_t noise_op();
        return op_row(op_mode_t'($urandom_range(0, 3)), $urandom_range(0, 255),
                      $urandom_range(0, 127), $urandom_range(0, 255), $urandom_range(0, 7),
                      $urandom_range(0, 1023), 1'b0, 0, 1'b0);
    endfunction

    function automatic int pick_scale();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return 0;
        if (r < 50) return 1;
        if (r < 80) return 2;
        if (r < 90) return 3;
        return $urandom_range(4, 7);
    endfunction

    function automatic text_op_t rand_draw();
        text_op_t t;
        t       = noise_op();
        t.mode  = sgpf_pkg::MODE_DRAW;
        t.scale = 3'(pick_scale());
        if ($urandom_range(0, 9) < 7) t.x = 8'($urandom_range(0, 120));
        if ($urandom_range(0, 9) < 7) t.y = 7'($urandom_range(0, 60));
        if ($urandom_range(0, 2) != 0) t.ch = 8'($urandom_range(ASCII_SPACE, ASCII_DEL));
        return t;
    endfunction

    // A read that lands inside the area the last glyph covered, so it usually sees ink.
    function automatic text_op_t aimed_read(input text_op_t d);
        text_op_t t;
        int       span;
        int       px;
        int       py;
        span   = 8 * ((d.scale > MAX_SCALE) ? MAX_SCALE : ((d.scale == 0) ? 1 : int'(d.scale)));
        px     = int'(d.x) + $urandom_range(0, span - 1);
        py     = int'(d.y) + $urandom_range(0, span - 1);
        t      = noise_op();
        t.mode = sgpf_pkg::MODE_READ;
        if (px < SCREEN_WIDTH && py < SCREEN_HEIGHT) begin
            t.idx = 10'((py / 8) * SCREEN_WIDTH + px);
        end
        return t;
    endfunction

    task automatic send_op(input text_op_t t);
        if (tx_idle_on && $urandom_range(0, 2) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= t.mode;
        s_tdata  <= {4'b0, t.idx, t.scale, t.ch, t.y, t.x};
        cur_op   <= t;
        sent_ops++;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic run_scene();
        text_op_t d;
        if ($urandom_range(0, 4) == 0) begin
            send_op(op_row(sgpf_pkg::MODE_CLEAR, 0, 0, 0, 0, 0, 1'b0, 0, 1'b0));
        end
        repeat ($urandom_range(1, 5)) begin
            d = rand_draw();
            send_op(d);
            repeat ($urandom_range(0, 3)) send_op(aimed_read(d));
        end
        if ($urandom_range(0, 9) == 0) send_op(noise_op());
        repeat ($urandom_range(1, 2)) begin
            send_op(op_row(sgpf_pkg::MODE_COMMIT, $urandom_range(0, 255),
                           $urandom_range(0, 127), $urandom_range(0, 255),
                           $urandom_range(0, 7), $urandom_range(0, 1023), 1'b0, 0, 1'b0));
        end
    endtask

    // Random receiver backpressure in bursts, while rx_idle_on is set.
    always @(posedge aclk) begin
        if (rx_hold != 0) begin
            rx_hold  <= rx_hold - 1;
            m_tready <= 1'b0;
        end else if (rx_idle_on && $urandom_range(0, 15) == 0) begin
            rx_hold  <= $urandom_range(0, 11);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                want = apply_op(cur_op);
                if (cur_op.typed) begin
                    want.byte_value    = cur_op.typed_byte;
                    want.frame_changed = cur_op.typed_changed;
                end
                pending_results.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got.byte_value    = m_tdata[7:0];
                got.frame_changed = m_tdata[RES_CHANGED_BIT];
                if (pending_results.size() == 0) begin
                    $error("result transaction with nothing pending: m_tdata=%04h", m_tdata);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.byte_value !== want.byte_value) begin
                        $error("byte_value: expected %02h, got %02h",
                               want.byte_value, got.byte_value);
                        fail_count++;
                    end
                    if (got.frame_changed !== want.frame_changed) begin
                        $error("frame_changed: expected %0b, got %0b",
                               want.frame_changed, got.frame_changed);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL scaled_glyph_page_framebuffer");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < STORE_BYTES; i++) begin
            fb_model[i]     = 8'h00;
            shadow_model[i] = 8'h00;
        end
        shadow_ok = 1'b0;

        // mode, x, y, char, scale, byte index, typed, byte_value, frame_changed
        dir_ops.push_back(op_row(sgpf_pkg::MODE_READ,     0,   0,    0, 0,    0, 1, 0, 0));
        dir_ops.push_back(op_row(sgpf_pkg::MODE_READ,   255, 127,  255, 7, 1023, 1, 0, 0));
        dir_ops.push_back(op_row(sgpf_pkg::MODE_COMMIT,   0,   0,    0, 0,    0, 1, 0, 1));
        dir_ops.push_back(op_row(sgpf_pkg::MODE_COMMIT, 255, 127,  255, 7, 1023, 1, 0, 0));
        dir_ops.push_back(op_row(sgpf_pkg::MODE_DRAW,     0,   0,  "A", 1,    0, 1, 0, 0));
        dir_ops.push_back(op_row(sgpf_pkg::MODE_READ,     0,   0,    0, 0,    0, 0, 0, 0));
        dir_ops.push_back(op_row(sgpf_pkg::MODE_DRAW,   124,  60,  "z", 2,    0, 1, 0, 0));
        dir_ops.push_back(op_row(sgpf_pkg::MODE_READ,     0,   0,    0, 0,  941, 0, 0, 0));
        dir_ops.push_back(op_row(sgpf_pkg::MODE_DRAW,   255, 127, 8'hFF, 7,   0, 1, 0, 0));
        dir_ops.push_back(op_row(sgpf_pkg::MODE_DRAW,     0,   8, 8'h60, 0,   0, 1, 0, 0));
        dir_ops.push_back(op_row(sgpf_pkg::MODE_DRAW,    16,  16, 8'h1F, 5,   0, 1, 0, 0));
        dir_ops.push_back(op_row(sgpf_pkg::MODE_DRAW,    40,   0, 8'h5F, 3,   0, 1, 0, 0));
        dir_ops.push_back(op_row(sgpf_pkg::MODE_DRAW,    64,  32, 8'h20, 4,   0, 1, 0, 0));
        dir_ops.push_back(op_row(sgpf_pkg::MODE_DRAW,   100,  40, 8'h7B, 1,   0, 1, 0, 0));
        dir_ops.push_back(op_row(sgpf_pkg::MODE_DRAW,    80,  20,  "a", 1,    0, 1, 0, 0));
        dir_ops.push_back(op_row(sgpf_pkg::MODE_READ,     0,   0,    0, 0,  273, 0, 0, 0));
        dir_ops.push_back(op_row(sgpf_pkg::MODE_READ,     0,   0,    0, 0,  426, 0, 0, 0));
        dir_ops.push_back(op_row(sgpf_pkg::MODE_READ,     0,   0,    0, 0,  338, 0, 0, 0));
        dir_ops.push_back(op_row(sgpf_pkg::MODE_COMMIT,   0,   0,    0, 0,    0, 1, 0, 1));
        dir_ops.push_back(op_row(sgpf_pkg::MODE_COMMIT,   0,   0,    0, 0,    0, 1, 0, 0));
        dir_ops.push_back(op_row(sgpf_pkg::MODE_READ,     0,   0,    0, 0,    1, 0, 0, 0));
        dir_ops.push_back(op_row(sgpf_pkg::MODE_CLEAR,  255, 127,  255, 7, 1023, 1, 0, 0));
        dir_ops.push_back(op_row(sgpf_pkg::MODE_READ,     0,   0,    0, 0,  272, 1, 0, 0));
        dir_ops.push_back(op_row(sgpf_pkg::MODE_COMMIT,   0,   0,    0, 0,    0, 1, 0, 1));
        dir_ops.push_back(op_row(sgpf_pkg::MODE_COMMIT,   0,   0,    0, 0,    0, 1, 0, 0));

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        foreach (dir_ops[i]) begin
            // Let the sender go quiet until every transaction so far has come back.
            if (dir_ops[i].mode == sgpf_pkg::MODE_CLEAR) drain_results();
            send_op(dir_ops[i]);
        end
        drain_results();

        while (sent_ops < dir_ops.size() + RANDOM_OPS) begin
            if (sent_ops < dir_ops.size() + RANDOM_OPS - QUIET_TAIL) begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
            end else begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            run_scene();
        end

        drain_results();
        repeat (SETTLE) @(posedge aclk);
        if (fail_count == 0) begin
            $display("PASS scaled_glyph_page_framebuffer");
        end else begin
            $display("FAIL scaled_glyph_page_framebuffer");
        end
        $finish;
    end

endmodule
